@@ hdl/pkv_pkg.sv @@
// ----------------------------------------------------------------------------
// pkv_pkg
// Types and constants shared by the paged key/value cache address calculator.
// ----------------------------------------------------------------------------
package pkv_pkg;

  localparam int unsigned PAGE_W   = 16;
  localparam int unsigned HEAD_W   = 8;
  localparam int unsigned TOKEN_W  = 8;
  localparam int unsigned DIM_W    = 9;
  localparam int unsigned SLOT_W   = 24;
  localparam int unsigned OFFSET_W = 44;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned BC_W  = 17;
  localparam int unsigned HC_W  = 9;
  localparam int unsigned TPB_W = 9;
  localparam int unsigned HW_W  = 10;
  localparam int unsigned ET_W  = 2;

  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam int unsigned DIV_STEP   = 6;
  localparam int unsigned DIV_STAGES = SLOT_W / DIV_STEP;

  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_COUNT      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_COUNT       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TOKENS_PER_BLOCK = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEAD_WIDTH       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_TYPE     = 3'd4;

  localparam logic [ET_W-1:0] ET_HALF   = 2'd0;
  localparam logic [ET_W-1:0] ET_BF16   = 2'd1;
  localparam logic [ET_W-1:0] ET_SINGLE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAGE   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COORD  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SLOT   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CONFIG = 3'd4;

  typedef struct packed {
    logic               command;
    logic               kind;
    logic [PAGE_W-1:0]  page;
    logic [HEAD_W-1:0]  head;
    logic [TOKEN_W-1:0] token;
    logic [DIM_W-1:0]   dim;
    logic [SLOT_W-1:0]  slot;
  } req_t;

  typedef struct packed {
    logic [TPB_W-1:0]  rem;
    logic [SLOT_W-1:0] quo;
  } divst_t;

endpackage

@@ hdl/paged_kv_address_calc.sv @@
// ----------------------------------------------------------------------------
// paged_kv_address_calc
// Byte offset of one element in a paged key/value cache, fully pipelined.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge with start high and busy low. The
// request names an element by page, head, token and dim, or by a flat slot
// that a four-stage restoring divider splits into page and token. busy is
// held low, so a new transaction can be taken in every cycle.
// The result appears on out_offset and out_status with out_strobe high for
// one cycle. The pipeline consists of the input register, the four divider
// stages of six quotient bits each, and four arithmetic stages (offset
// products, element product, element sum, final add). Throughput is one
// transaction per cycle. The user writes the configuration registers through
// cfg_we, cfg_index and cfg_data only while no transaction is in flight; the
// block does not enforce this. Derived page and cache sizes (hct_r, hcth_r,
// pb_r, cache_r) must settle before any new transaction needs them.
// Reset clears the valid bits of the pipeline and loads the configuration
// reset values. The receiver cannot stall; every result is taken in the
// cycle in which it is shown.
// ----------------------------------------------------------------------------
module paged_kv_address_calc #(
  parameter int unsigned MAX_BLOCKS     = 65536,
  parameter int unsigned MAX_HEADS      = 256,
  parameter int unsigned MAX_BLOCK_SIZE = 256,
  parameter int unsigned MAX_HEAD_SIZE  = 512
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_command,
  input  logic                                in_kind,
  input  logic [pkv_pkg::PAGE_W-1:0]          in_page,
  input  logic [pkv_pkg::HEAD_W-1:0]          in_head,
  input  logic [pkv_pkg::TOKEN_W-1:0]         in_token,
  input  logic [pkv_pkg::DIM_W-1:0]           in_dim,
  input  logic [pkv_pkg::SLOT_W-1:0]          in_slot,
  output logic                                out_strobe,
  output logic [pkv_pkg::OFFSET_W-1:0]        out_offset,
  output logic [pkv_pkg::STATUS_W-1:0]        out_status,
  input  logic                                cfg_we,
  input  logic [pkv_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pkv_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pkv_pkg::*;

  logic [BC_W-1:0]  cfg_bc_r;
  logic [HC_W-1:0]  cfg_hc_r;
  logic [TPB_W-1:0] cfg_tpb_r;
  logic [HW_W-1:0]  cfg_hw_r;
  logic [ET_W-1:0]  cfg_et_r;

  logic [17:0]         hct_r;
  logic [27:0]         hcth_r;
  logic [29:0]         pb_r;
  logic [OFFSET_W-1:0] cache_r;
  logic [46:0]         cache_prod;

  logic v0_r;
  req_t req0_r;

  logic   vsrc  [DIV_STAGES];
  req_t   rsrc  [DIV_STAGES];
  divst_t dsrc  [DIV_STAGES];
  logic   vd_r  [DIV_STAGES];
  req_t   reqd_r[DIV_STAGES];
  divst_t divd_r[DIV_STAGES];

  logic                v1_r;
  logic [STATUS_W-1:0] st1_r;
  logic                kind1_r;
  logic [OFFSET_W-1:0] pgoff1_r;
  logic [16:0]         ht1_r;
  logic [18:0]         tokhw1_r;
  logic [DIM_W-1:0]    dim1_r;

  logic [SLOT_W-1:0]   page_sel;
  logic [TPB_W-1:0]    tok_sel;
  logic                cfg_bad;
  logic                range_err;
  logic                coord_err;
  logic [STATUS_W-1:0] st1_nxt;
  logic [46:0]         pg_prod;
  logic [16:0]         ht_prod;
  logic [18:0]         tokhw_prod;

  logic                v2_r;
  logic [STATUS_W-1:0] st2_r;
  logic [OFFSET_W-1:0] base2_r;
  logic [26:0]         hth2_r;
  logic [18:0]         tokhw2_r;
  logic [DIM_W-1:0]    dim2_r;
  logic [26:0]         hth_prod;

  logic                v3_r;
  logic [STATUS_W-1:0] st3_r;
  logic [OFFSET_W-1:0] base3_r;
  logic [29:0]         elemb3_r;
  logic [27:0]         elem_sum;
  logic [29:0]         elemb_nxt;

  logic                out_strobe_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [OFFSET_W-1:0] out_offset_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_bc_r  <= BC_W'(1);
      cfg_hc_r  <= HC_W'(1);
      cfg_tpb_r <= TPB_W'(1);
      cfg_hw_r  <= HW_W'(1);
      cfg_et_r  <= ET_HALF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_COUNT:      cfg_bc_r  <= cfg_data[BC_W-1:0];
        CFG_HEAD_COUNT:       cfg_hc_r  <= cfg_data[HC_W-1:0];
        CFG_TOKENS_PER_BLOCK: cfg_tpb_r <= cfg_data[TPB_W-1:0];
        CFG_HEAD_WIDTH:       cfg_hw_r  <= cfg_data[HW_W-1:0];
        CFG_ELEMENT_TYPE:     cfg_et_r  <= cfg_data[ET_W-1:0];
        default: ;
      endcase
    end
  end

  // Page and cache sizes follow the configuration through hct_r, hcth_r, pb_r and cache_r.
  assign cache_prod = cfg_bc_r * pb_r;

  always_ff @(posedge clk) begin
    hct_r   <= cfg_hc_r * cfg_tpb_r;
    hcth_r  <= hct_r * cfg_hw_r;
    pb_r    <= (cfg_et_r == ET_SINGLE) ? {hcth_r, 2'b00} : {1'b0, hcth_r, 1'b0};
    cache_r <= cache_prod[OFFSET_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    req0_r.command <= in_command;
    req0_r.kind    <= in_kind;
    req0_r.page    <= in_page;
    req0_r.head    <= in_head;
    req0_r.token   <= in_token;
    req0_r.dim     <= in_dim;
    req0_r.slot    <= in_slot;
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    divst_t div_nxt;

    if (k == 0) begin : g_first
      assign vsrc[k] = v0_r;
      assign rsrc[k] = req0_r;
      assign dsrc[k] = '0;
    end else begin : g_next
      assign vsrc[k] = vd_r[k-1];
      assign rsrc[k] = reqd_r[k-1];
      assign dsrc[k] = divd_r[k-1];
    end

    always_comb begin
      logic [TPB_W:0] trial;
      logic           qbit;
      div_nxt = dsrc[k];
      for (int j = 0; j < DIV_STEP; j++) begin
        trial = {div_nxt.rem, rsrc[k].slot[SLOT_W-1-k*DIV_STEP-j]};
        if (trial >= {1'b0, cfg_tpb_r}) begin
          trial = trial - {1'b0, cfg_tpb_r};
          qbit  = 1'b1;
        end else begin
          qbit  = 1'b0;
        end
        div_nxt.rem = trial[TPB_W-1:0];
        div_nxt.quo = {div_nxt.quo[SLOT_W-2:0], qbit};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k] <= 1'b0;
      end else begin
        vd_r[k] <= vsrc[k];
      end
    end

    always_ff @(posedge clk) begin
      reqd_r[k] <= rsrc[k];
      divd_r[k] <= div_nxt;
    end
  end

  always_comb begin
    page_sel = reqd_r[DIV_STAGES-1].command ? divd_r[DIV_STAGES-1].quo
                                            : {8'b0, reqd_r[DIV_STAGES-1].page};
    tok_sel  = reqd_r[DIV_STAGES-1].command ? divd_r[DIV_STAGES-1].rem
                                            : {1'b0, reqd_r[DIV_STAGES-1].token};
    cfg_bad  = (cfg_bc_r == '0) || (32'(cfg_bc_r) > MAX_BLOCKS) ||
               (cfg_hc_r == '0) || (32'(cfg_hc_r) > MAX_HEADS) ||
               (cfg_tpb_r == '0) || (32'(cfg_tpb_r) > MAX_BLOCK_SIZE) ||
               (cfg_hw_r == '0) || (32'(cfg_hw_r) > MAX_HEAD_SIZE) ||
               (cfg_et_r > ET_SINGLE);
    range_err = page_sel >= {7'b0, cfg_bc_r};
    coord_err = ({1'b0, reqd_r[DIV_STAGES-1].head} >= cfg_hc_r) ||
                (tok_sel >= cfg_tpb_r) ||
                ({1'b0, reqd_r[DIV_STAGES-1].dim} >= cfg_hw_r);
    if (cfg_bad) begin
      st1_nxt = ST_CONFIG;
    end else if (range_err) begin
      st1_nxt = reqd_r[DIV_STAGES-1].command ? ST_SLOT : ST_PAGE;
    end else if (coord_err) begin
      st1_nxt = ST_COORD;
    end else begin
      st1_nxt = ST_OK;
    end
    pg_prod    = page_sel[16:0] * pb_r;
    ht_prod    = reqd_r[DIV_STAGES-1].head * cfg_tpb_r;
    tokhw_prod = tok_sel * cfg_hw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= vd_r[DIV_STAGES-1];
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    st1_r    <= st1_nxt;
    kind1_r  <= reqd_r[DIV_STAGES-1].kind;
    pgoff1_r <= pg_prod[OFFSET_W-1:0];
    ht1_r    <= ht_prod;
    tokhw1_r <= tokhw_prod;
    dim1_r   <= reqd_r[DIV_STAGES-1].dim;
  end

  assign hth_prod = ht1_r * cfg_hw_r;

  always_ff @(posedge clk) begin
    st2_r    <= st1_r;
    base2_r  <= (kind1_r ? cache_r : '0) + pgoff1_r;
    hth2_r   <= hth_prod;
    tokhw2_r <= tokhw1_r;
    dim2_r   <= dim1_r;
  end

  always_comb begin
    elem_sum  = {1'b0, hth2_r} + {9'b0, tokhw2_r} + {19'b0, dim2_r};
    elemb_nxt = (cfg_et_r == ET_SINGLE) ? {elem_sum, 2'b00} : {1'b0, elem_sum, 1'b0};
  end

  always_ff @(posedge clk) begin
    st3_r    <= st2_r;
    base3_r  <= base2_r;
    elemb3_r <= elemb_nxt;
  end

  assign out_offset_nxt = (st3_r == ST_OK) ? base3_r + {14'b0, elemb3_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    out_offset_r <= out_offset_nxt;
    out_status_r <= st3_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_offset = out_offset_r;
  assign out_status = out_status_r;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the paged key/value cache address calculator.
// A scoreboard object keeps its own copy of the configuration, works out the
// offset and status of every accepted transaction and compares them, in order,
// with the results on the strobe. A short directed sequence covers the field
// extremes and every status; random phases then rewrite the configuration
// (legal, extreme and illegal settings) and send mostly well-formed requests
// with random content, mixed with out-of-range and fully random ones.
// ----------------------------------------------------------------------------
module testbench;
  import pkv_pkg::*;

  localparam int unsigned MAX_BLOCKS     = 65536;
  localparam int unsigned MAX_HEADS      = 256;
  localparam int unsigned MAX_BLOCK_SIZE = 256;
  localparam int unsigned MAX_HEAD_SIZE  = 512;
  localparam int unsigned ITEM_TARGET    = 1950;
  localparam int unsigned SLOT_SPAN      = 1 << SLOT_W;

  localparam logic CMD_COORD  = 1'b0;
  localparam logic CMD_SLOT   = 1'b1;
  localparam logic KIND_KEY   = 1'b0;
  localparam logic KIND_VALUE = 1'b1;

  typedef struct packed {
    logic [BC_W-1:0]  blocks;
    logic [HC_W-1:0]  heads;
    logic [TPB_W-1:0] tokens;
    logic [HW_W-1:0]  width;
    logic [ET_W-1:0]  etype;
  } kv_cfg_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [STATUS_W-1:0] status;
  } addr_result_t;

  class addr_scoreboard;
    kv_cfg_t      cfg;
    addr_result_t pending_q[$];
    int unsigned  errors;

    function new();
      cfg.blocks = BC_W'(1);
      cfg.heads  = HC_W'(1);
      cfg.tokens = TPB_W'(1);
      cfg.width  = HW_W'(1);
      cfg.etype  = ET_HALF;
      errors     = 0;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_BLOCK_COUNT:      cfg.blocks = data[BC_W-1:0];
        CFG_HEAD_COUNT:       cfg.heads  = data[HC_W-1:0];
        CFG_TOKENS_PER_BLOCK: cfg.tokens = data[TPB_W-1:0];
        CFG_HEAD_WIDTH:       cfg.width  = data[HW_W-1:0];
        CFG_ELEMENT_TYPE:     cfg.etype  = data[ET_W-1:0];
        default: ;
      endcase
    endfunction

    function bit config_illegal();
      return cfg.blocks == 0 || cfg.blocks > MAX_BLOCKS ||
             cfg.heads == 0 || cfg.heads > MAX_HEADS ||
             cfg.tokens == 0 || cfg.tokens > MAX_BLOCK_SIZE ||
             cfg.width == 0 || cfg.width > MAX_HEAD_SIZE ||
             cfg.etype > ET_SINGLE;
    endfunction

    function addr_result_t compute_address(req_t r);
      longint unsigned elem_bytes, page_bytes, cache_bytes, page_idx, token_idx, element, sum;
      addr_result_t res;
      res.offset = '0;
      res.status = ST_OK;
      if (config_illegal()) begin
        res.status = ST_CONFIG;
      end else begin
        elem_bytes  = (cfg.etype == ET_SINGLE) ? 4 : 2;
        page_bytes  = longint'(cfg.heads) * cfg.tokens * cfg.width * elem_bytes;
        cache_bytes = longint'(cfg.blocks) * page_bytes;
        page_idx    = r.page;
        token_idx   = r.token;
        if (r.command == CMD_SLOT) begin
          if (longint'(r.slot) >= longint'(cfg.blocks) * cfg.tokens) begin
            res.status = ST_SLOT;
          end else begin
            page_idx  = longint'(r.slot) / cfg.tokens;
            token_idx = longint'(r.slot) % cfg.tokens;
          end
        end else if (r.page >= cfg.blocks) begin
          res.status = ST_PAGE;
        end
        if (res.status == ST_OK &&
            (r.head >= cfg.heads || token_idx >= cfg.tokens || r.dim >= cfg.width)) begin
          res.status = ST_COORD;
        end
        if (res.status == ST_OK) begin
          element = (longint'(r.head) * cfg.tokens + token_idx) * cfg.width + r.dim;
          sum = ((r.kind == KIND_VALUE) ? cache_bytes : 0) + page_idx * page_bytes +
                element * elem_bytes;
          res.offset = sum[OFFSET_W-1:0];
        end
      end
      return res;
    endfunction

    function void note_request(req_t r);
      pending_q.push_back(compute_address(r));
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [OFFSET_W-1:0] offset, logic [STATUS_W-1:0] status);
      addr_result_t exp_res;
      if (pending_q.size() == 0) begin
        report($sformatf("result offset=%0h status=%0d with no transaction pending",
                         offset, status));
      end else begin
        exp_res = pending_q.pop_front();
        if (status !== exp_res.status)
          report($sformatf("status %0d, expected %0d", status, exp_res.status));
        if (offset !== exp_res.offset)
          report($sformatf("offset %0h, expected %0h", offset, exp_res.offset));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic                   in_command;
  logic                   in_kind;
  logic [PAGE_W-1:0]      in_page;
  logic [HEAD_W-1:0]      in_head;
  logic [TOKEN_W-1:0]     in_token;
  logic [DIM_W-1:0]       in_dim;
  logic [SLOT_W-1:0]      in_slot;
  logic                   out_strobe;
  logic [OFFSET_W-1:0]    out_offset;
  logic [STATUS_W-1:0]    out_status;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  addr_scoreboard sb = new();
  int unsigned    idle_pct;

  paged_kv_address_calc #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .MAX_HEADS      (MAX_HEADS),
    .MAX_BLOCK_SIZE (MAX_BLOCK_SIZE),
    .MAX_HEAD_SIZE  (MAX_HEAD_SIZE)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_kind    (in_kind),
    .in_page    (in_page),
    .in_head    (in_head),
    .in_token   (in_token),
    .in_dim     (in_dim),
    .in_slot    (in_slot),
    .out_strobe (out_strobe),
    .out_offset (out_offset),
    .out_status (out_status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_offset, out_status);
  end

  initial begin
    #500000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned pick_below(int unsigned limit);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return limit - 1;
      default: return $urandom_range(0, limit - 1);
    endcase
  endfunction

  function automatic int unsigned pick_size(int unsigned max_size);
    case ($urandom_range(0, 7))
      0:       return 1;
      1:       return max_size;
      2, 3:    return $urandom_range(1, max_size);
      default: return $urandom_range(1, (max_size < 16) ? max_size : 16);
    endcase
  endfunction

  function automatic kv_cfg_t make_cfg(int unsigned blocks, int unsigned heads,
                                       int unsigned tokens, int unsigned width,
                                       logic [ET_W-1:0] etype);
    kv_cfg_t c;
    c.blocks = BC_W'(blocks);
    c.heads  = HC_W'(heads);
    c.tokens = TPB_W'(tokens);
    c.width  = HW_W'(width);
    c.etype  = etype;
    return c;
  endfunction

  function automatic kv_cfg_t random_cfg(bit illegal);
    kv_cfg_t c;
    c = make_cfg(pick_size(MAX_BLOCKS), pick_size(MAX_HEADS), pick_size(MAX_BLOCK_SIZE),
                 pick_size(MAX_HEAD_SIZE), ET_W'($urandom_range(0, 2)));
    if (illegal) begin
      case ($urandom_range(0, 4))
        0: c.blocks = $urandom_range(0, 1) ? '0 : BC_W'($urandom_range(MAX_BLOCKS + 1, 131071));
        1: c.heads  = $urandom_range(0, 1) ? '0 : HC_W'($urandom_range(MAX_HEADS + 1, 511));
        2: c.tokens = $urandom_range(0, 1) ? '0 :
                      TPB_W'($urandom_range(MAX_BLOCK_SIZE + 1, 511));
        3: c.width  = $urandom_range(0, 1) ? '0 : HW_W'($urandom_range(MAX_HEAD_SIZE + 1, 1023));
        default: c.etype = 2'd3;
      endcase
    end
    return c;
  endfunction

  function automatic req_t make_req(logic command, logic kind, int unsigned page,
                                    int unsigned head, int unsigned token,
                                    int unsigned dim, int unsigned slot);
    req_t r;
    r.command = command;
    r.kind    = kind;
    r.page    = PAGE_W'(page);
    r.head    = HEAD_W'(head);
    r.token   = TOKEN_W'(token);
    r.dim     = DIM_W'(dim);
    r.slot    = SLOT_W'(slot);
    return r;
  endfunction

  function automatic req_t random_req(kv_cfg_t c, bit illegal);
    req_t        r;
    int unsigned sel;
    int unsigned slot_lim;
    r = make_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, $urandom,
                 $urandom, $urandom, $urandom);
    sel = $urandom_range(0, 99);
    if (illegal || sel < 10) return r;
    slot_lim = c.blocks * c.tokens;
    r.head = HEAD_W'(pick_below(c.heads));
    r.dim  = DIM_W'(pick_below(c.width));
    if (r.command == CMD_SLOT) begin
      r.slot = SLOT_W'(pick_below(slot_lim));
    end else begin
      r.page  = PAGE_W'(pick_below(c.blocks));
      r.token = TOKEN_W'(pick_below(c.tokens));
    end
    if (sel < 30) begin
      case ($urandom_range(0, 3))
        0: begin
          if (r.command == CMD_SLOT) begin
            if (slot_lim < SLOT_SPAN) r.slot = SLOT_W'($urandom_range(slot_lim, SLOT_SPAN - 1));
          end else if (c.blocks < MAX_BLOCKS) begin
            r.page = PAGE_W'($urandom_range(c.blocks, MAX_BLOCKS - 1));
          end
        end
        1: if (c.heads < MAX_HEADS) r.head = HEAD_W'($urandom_range(c.heads, MAX_HEADS - 1));
        2: if (c.tokens < MAX_BLOCK_SIZE)
             r.token = TOKEN_W'($urandom_range(c.tokens, MAX_BLOCK_SIZE - 1));
        default: if (c.width < MAX_HEAD_SIZE)
                   r.dim = DIM_W'($urandom_range(c.width, MAX_HEAD_SIZE - 1));
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input req_t r);
    int unsigned gap;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 13);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    in_command <= r.command;
    in_kind    <= r.kind;
    in_page    <= r.page;
    in_head    <= r.head;
    in_token   <= r.token;
    in_dim     <= r.dim;
    in_slot    <= r.slot;
    do @(posedge clk); while (busy);
    sb.note_request(r);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic reconfigure(input kv_cfg_t c);
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    drain();
    for (int i = 0; i < 5; i++) begin
      case (i)
        0:       begin index = CFG_BLOCK_COUNT;      data = CFG_DATA_W'(c.blocks); end
        1:       begin index = CFG_HEAD_COUNT;       data = CFG_DATA_W'(c.heads);  end
        2:       begin index = CFG_TOKENS_PER_BLOCK; data = CFG_DATA_W'(c.tokens); end
        3:       begin index = CFG_HEAD_WIDTH;       data = CFG_DATA_W'(c.width);  end
        default: begin index = CFG_ELEMENT_TYPE;     data = CFG_DATA_W'(c.etype);  end
      endcase
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= index;
      cfg_data  <= data;
      @(posedge clk);
      sb.set_register(index, data);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    kv_cfg_t     c;
    bit          illegal;
    int unsigned sent;
    int unsigned phase;
    int unsigned count;
    int unsigned guard;

    rst_n      = 1'b0;
    start      = 1'b0;
    in_command = CMD_COORD;
    in_kind    = KIND_KEY;
    in_page    = '0;
    in_head    = '0;
    in_token   = '0;
    in_dim     = '0;
    in_slot    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_BLOCK_COUNT;
    cfg_data   = '0;
    idle_pct   = 15;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Configuration after reset: one page, one head, one token, one element.
    send_request(make_req(CMD_COORD, KIND_KEY, 0, 0, 0, 0, 0));
    send_request(make_req(CMD_COORD, KIND_VALUE, 0, 0, 0, 0, 24'hFFFFFF));
    send_request(make_req(CMD_SLOT, KIND_VALUE, 16'hFFFF, 0, 8'hFF, 0, 0));
    send_request(make_req(CMD_SLOT, KIND_KEY, 0, 0, 0, 0, 1));
    send_request(make_req(CMD_COORD, KIND_KEY, 1, 0, 0, 0, 0));
    send_request(make_req(CMD_COORD, KIND_KEY, 0, 1, 0, 0, 0));
    send_request(make_req(CMD_COORD, KIND_VALUE, 16'hFFFF, 8'hFF, 8'hFF, 9'h1FF, 0));

    reconfigure(make_cfg(1000, 8, 16, 64, ET_SINGLE));
    send_request(make_req(CMD_COORD, KIND_VALUE, 999, 7, 15, 63, 0));
    send_request(make_req(CMD_COORD, KIND_KEY, 1000, 0, 0, 0, 0));
    send_request(make_req(CMD_COORD, KIND_KEY, 1000, 8, 0, 0, 0));
    send_request(make_req(CMD_COORD, KIND_KEY, 3, 8, 0, 0, 0));
    send_request(make_req(CMD_COORD, KIND_KEY, 3, 0, 16, 0, 0));
    send_request(make_req(CMD_COORD, KIND_VALUE, 3, 0, 0, 64, 0));
    send_request(make_req(CMD_SLOT, KIND_VALUE, 16'hFFFF, 7, 8'hFF, 63, 15999));
    send_request(make_req(CMD_SLOT, KIND_KEY, 0, 0, 0, 0, 16000));
    send_request(make_req(CMD_SLOT, KIND_KEY, 0, 8, 0, 0, 5));

    reconfigure(make_cfg(MAX_BLOCKS, MAX_HEADS, MAX_BLOCK_SIZE, MAX_HEAD_SIZE, ET_BF16));
    send_request(make_req(CMD_COORD, KIND_VALUE, 16'hFFFF, 8'hFF, 8'hFF, 9'h1FF, 0));
    send_request(make_req(CMD_SLOT, KIND_VALUE, 0, 8'hFF, 0, 9'h1FF, 24'hFFFFFF));
    send_request(make_req(CMD_COORD, KIND_KEY, 0, 0, 0, 0, 0));

    reconfigure(make_cfg(0, 8, 16, 64, ET_HALF));
    send_request(make_req(CMD_COORD, KIND_KEY, 0, 0, 0, 0, 0));
    reconfigure(make_cfg(4, 8, 16, 64, 2'd3));
    send_request(make_req(CMD_SLOT, KIND_VALUE, 0, 0, 0, 0, 0));
    reconfigure(make_cfg(4, 8, 16, MAX_HEAD_SIZE + 1, ET_SINGLE));
    send_request(make_req(CMD_COORD, KIND_KEY, 0, 0, 0, 0, 0));

    sent  = 0;
    phase = 0;
    while (sent < ITEM_TARGET) begin
      illegal = 1'b0;
      if (phase == 0) begin
        c = make_cfg(MAX_BLOCKS, MAX_HEADS, MAX_BLOCK_SIZE, MAX_HEAD_SIZE, ET_SINGLE);
      end else if (phase == 1) begin
        c = make_cfg(1, 1, 1, 1, ET_W'($urandom_range(0, 2)));
      end else begin
        illegal = ($urandom_range(0, 5) == 0);
        c = random_cfg(illegal);
      end
      count = illegal ? 20 : $urandom_range(80, 160);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 40;
      endcase
      reconfigure(c);
      for (int i = 0; i < count && sent < ITEM_TARGET; i++) begin
        if (sent >= ITEM_TARGET - ITEM_TARGET / 10) idle_pct = 0;
        send_request(random_req(c, illegal));
        sent++;
      end
      phase++;
    end

    @(negedge clk);
    start <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    if (sb.pending() != 0)
      sb.report($sformatf("%0d transactions never answered", sb.pending()));
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
